### sv/bet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bet_pkg;

	// button store
	localparam int BTN_COUNT   = 11;
	localparam int IDX_W       = $clog2(BTN_COUNT);
	localparam int MASK_W      = 11;
	localparam int TIME_W      = 32;
	localparam int AXIS_W      = 16;
	localparam int NUM_REAL    = 3;
	localparam int NUM_AXES    = 4;
	localparam int AXIS_BASE   = NUM_REAL;

	// request codes on tuser
	localparam logic [2:0] REQ_EVENT   = 3'd0;
	localparam logic [2:0] REQ_FLUSH   = 3'd1;
	localparam logic [2:0] REQ_RD_CNT  = 3'd2;
	localparam logic [2:0] REQ_RD_STATE = 3'd3;
	localparam logic [2:0] REQ_RD_HOLD = 3'd4;

	// event mask bits
	localparam int EV_LEFT_PRESS    = 1;
	localparam int EV_LEFT_RELEASE  = 2;
	localparam int EV_RIGHT_PRESS   = 3;
	localparam int EV_RIGHT_RELEASE = 4;
	localparam int EV_MID_PRESS     = 5;
	localparam int EV_MID_RELEASE   = 6;
	localparam int EV_AXIS_Z        = 11;
	localparam int EV_AXIS_PITCH    = 12;
	localparam int EV_AXIS_BANK     = 13;
	localparam int EV_AXIS_HEADING  = 14;

	// command queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// config register map
	localparam logic REG_AXIS_MODE = 1'b0;
	localparam logic REG_ENABLE    = 1'b1;

	typedef enum logic [2:0] {
		K_NOP,
		K_OFF,
		K_EVENT,
		K_FLUSH,
		K_RD_CNT,
		K_RD_STATE,
		K_RD_HOLD
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [NUM_REAL-1:0]   btn_press;
		logic [NUM_REAL-1:0]   btn_release;
		logic [NUM_AXES-1:0]   axis_chg;
		logic [NUM_AXES-1:0]   axis_pos;
		logic [NUM_AXES-1:0]   axis_neg;
		logic [TIME_W-1:0]     now;
		logic [IDX_W-1:0]      idx;
	} cmd_t;

endpackage

`default_nettype wire

### sv/bet_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bet_front import bet_pkg::*; (
	input  wire logic [2:0]          req_type,
	input  wire logic [15:0]         event_mask,
	input  wire logic [AXIS_W-1:0]   axis_z,
	input  wire logic [AXIS_W-1:0]   axis_pitch,
	input  wire logic [AXIS_W-1:0]   axis_bank,
	input  wire logic [AXIS_W-1:0]   axis_heading,
	input  wire logic [TIME_W-1:0]   timestamp,
	input  wire logic [3:0]          button_index,
	input  wire logic                axis_mode_enable,
	input  wire logic                block_enable,
	output cmd_t                     cmd
);

	logic                     idx_ok;
	logic [NUM_AXES-1:0]      axis_sign;
	logic [NUM_AXES-1:0]      axis_nz;

	assign idx_ok = ((IDX_W + 1)'(button_index) < (IDX_W + 1)'(BTN_COUNT));

	assign axis_sign = {axis_heading[AXIS_W-1], axis_bank[AXIS_W-1],
		axis_pitch[AXIS_W-1], axis_z[AXIS_W-1]};
	assign axis_nz   = {|axis_heading, |axis_bank, |axis_pitch, |axis_z};

	always_comb begin
		cmd             = '0;
		cmd.kind        = K_NOP;
		cmd.btn_press   = {event_mask[EV_MID_PRESS], event_mask[EV_RIGHT_PRESS],
			event_mask[EV_LEFT_PRESS]};
		cmd.btn_release = {event_mask[EV_MID_RELEASE], event_mask[EV_RIGHT_RELEASE],
			event_mask[EV_LEFT_RELEASE]};
		cmd.axis_chg    = {event_mask[EV_AXIS_HEADING], event_mask[EV_AXIS_BANK],
			event_mask[EV_AXIS_PITCH], event_mask[EV_AXIS_Z]} & {NUM_AXES{axis_mode_enable}};
		cmd.axis_pos    = ~axis_sign & axis_nz;
		cmd.axis_neg    = axis_sign;
		cmd.now         = timestamp;
		cmd.idx         = button_index[IDX_W-1:0];
		if (!block_enable) begin
			cmd.kind = K_OFF;
		end else begin
			unique case (req_type)
				REQ_EVENT:    cmd.kind = K_EVENT;
				REQ_FLUSH:    cmd.kind = K_FLUSH;
				REQ_RD_CNT:   cmd.kind = idx_ok ? K_RD_CNT : K_NOP;
				REQ_RD_STATE: cmd.kind = idx_ok ? K_RD_STATE : K_NOP;
				REQ_RD_HOLD:  cmd.kind = idx_ok ? K_RD_HOLD : K_NOP;
				default:      cmd.kind = K_NOP;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/bet_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bet_queue import bet_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output cmd_t      head
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/bet_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bet_back import bet_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	input  wire cmd_t         cmd,
	output logic              cmd_pop,
	output logic              res_valid,
	input  wire logic         res_ready,
	output logic [TIME_W-1:0] reply_value,
	output logic [MASK_W-1:0] pressed_mask
);

	logic [BTN_COUNT-1:0]   held_q;
	logic [TIME_W-1:0]      press_time_q [BTN_COUNT];
	logic [TIME_W-1:0]      hold_total_q [BTN_COUNT];
	logic [TIME_W-1:0]      down_cnt_q   [BTN_COUNT];

	logic [BTN_COUNT-1:0]   held_d;
	logic [TIME_W-1:0]      press_time_d [BTN_COUNT];
	logic [TIME_W-1:0]      hold_total_d [BTN_COUNT];
	logic [TIME_W-1:0]      down_cnt_d   [BTN_COUNT];
	logic [TIME_W-1:0]      reply_d;
	logic [MASK_W-1:0]      mask_d;

	logic                   out_valid_q;
	logic [TIME_W-1:0]      reply_q;
	logic [MASK_W-1:0]      mask_q;

	logic [BTN_COUNT-1:0]   go_press;
	logic [BTN_COUNT-1:0]   go_count;
	logic [BTN_COUNT-1:0]   go_release;
	logic [TIME_W-1:0]      elapsed_sel;

	assign cmd_pop      = cmd_valid && (!out_valid_q || res_ready);
	assign res_valid    = out_valid_q;
	assign reply_value  = reply_q;
	assign pressed_mask = mask_q;
	assign elapsed_sel  = cmd.now - press_time_q[cmd.idx];

	// per-button event decisions, all buttons in parallel
	always_comb begin
		go_press   = '0;
		go_count   = '0;
		go_release = '0;
		for (int i = 0; i < BTN_COUNT; i++) begin
			if (i < NUM_REAL) begin
				// press bit wins; release only counts when press is clear
				go_press[i]   = cmd.btn_press[i] && !held_q[i];
				go_count[i]   = cmd.btn_press[i];
				go_release[i] = !cmd.btn_press[i] && cmd.btn_release[i] && held_q[i];
			end else if (i < AXIS_BASE + 2 * NUM_AXES) begin
				// even offset: positive direction, odd offset: negative
				if (((i - AXIS_BASE) % 2) == 0) begin
					go_press[i] = cmd.axis_chg[(i - AXIS_BASE) / 2] && !held_q[i]
						&& cmd.axis_pos[(i - AXIS_BASE) / 2];
				end else begin
					go_press[i] = cmd.axis_chg[(i - AXIS_BASE) / 2] && !held_q[i]
						&& cmd.axis_neg[(i - AXIS_BASE) / 2];
				end
				go_count[i]   = go_press[i];
				go_release[i] = cmd.axis_chg[(i - AXIS_BASE) / 2] && held_q[i];
			end
		end
	end

	always_comb begin
		held_d       = held_q;
		press_time_d = press_time_q;
		hold_total_d = hold_total_q;
		down_cnt_d   = down_cnt_q;
		reply_d      = '0;
		unique case (cmd.kind)
			K_EVENT: begin
				for (int i = 0; i < BTN_COUNT; i++) begin
					if (go_press[i]) begin
						held_d[i]       = 1'b1;
						press_time_d[i] = cmd.now;
					end
					if (go_count[i]) begin
						down_cnt_d[i] = down_cnt_q[i] + 1'b1;
					end
					if (go_release[i]) begin
						held_d[i]       = 1'b0;
						hold_total_d[i] = hold_total_q[i] + (cmd.now - press_time_q[i]);
					end
				end
			end
			K_FLUSH: begin
				for (int i = 0; i < BTN_COUNT; i++) begin
					held_d[i]       = 1'b0;
					press_time_d[i] = cmd.now;
					hold_total_d[i] = '0;
					down_cnt_d[i]   = '0;
				end
			end
			K_RD_CNT: begin
				reply_d              = down_cnt_q[cmd.idx];
				down_cnt_d[cmd.idx]  = '0;
			end
			K_RD_STATE: begin
				reply_d = TIME_W'(held_q[cmd.idx]);
			end
			K_RD_HOLD: begin
				if (held_q[cmd.idx]) begin
					// live reading restarts the timestamp, total kept
					reply_d               = elapsed_sel;
					press_time_d[cmd.idx] = cmd.now;
				end else begin
					reply_d                = hold_total_q[cmd.idx];
					hold_total_d[cmd.idx]  = '0;
				end
			end
			K_NOP, K_OFF: begin
			end
			default: begin
			end
		endcase
		mask_d = (cmd.kind == K_OFF) ? '0 : held_d[MASK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int i = 0; i < BTN_COUNT; i++) begin
				press_time_q[i] <= '0;
				hold_total_q[i] <= '0;
				down_cnt_q[i]   <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				held_q       <= held_d;
				press_time_q <= press_time_d;
				hold_total_q <= hold_total_d;
				down_cnt_q   <= down_cnt_d;
				out_valid_q  <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			reply_q <= reply_d;
			mask_q  <= mask_d;
		end
	end

endmodule

`default_nettype wire

### sv/button_event_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Handshake              Contents
// s_axis     in   tvalid/tready          request: tuser = req_type, tdata = fields
// m_axis     out  tvalid/tready          reply value and pressed bitmap
// apb        in   psel/penable/pready    axis_mode_enable @0x0, block_enable @0x4
//
// One request per cycle while the queue has room: the front decodes it into a command in
// the same cycle it is taken; unless a reply stalls, the back applies one command per cycle
// to the flop-based button store and output register; m_axis_tvalid comes from the latter.
// A two-entry command queue splits front and back; s_axis_tready drops only when the
// queue is full, i.e. one reply stalled in the output register and two requests behind it.
// Reset clears all button state, the queue and both config bits.

module button_event_tracker import bet_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// request stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [15:0] event_mask, [31:16] axis_z, [47:32] axis_pitch, [63:48] axis_bank,
	// [79:64] axis_heading, [111:80] timestamp, [115:112] button_index, [119:116] zero
	input  wire logic [119:0] s_axis_tdata,
	// [2:0] req_type
	input  wire logic [2:0]   s_axis_tuser,
	// reply stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [31:0] reply_value, [42:32] pressed_mask, [47:43] zero
	output logic [47:0]       m_axis_tdata,
	// config
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic              axis_mode_q;
	logic              enable_q;
	logic              cfg_wr;

	cmd_t              front_cmd;
	cmd_t              head_cmd;
	logic              q_full;
	logic              q_not_empty;
	logic              q_pop;
	logic              push;
	logic [TIME_W-1:0] reply_value;
	logic [MASK_W-1:0] pressed_mask;

	// config port: register picked by address bit 2
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_ENABLE) ? {31'b0, enable_q} : {31'b0, axis_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_mode_q <= 1'b0;
			enable_q    <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_AXIS_MODE) begin
				axis_mode_q <= pwdata[0];
			end else begin
				enable_q <= pwdata[0];
			end
		end
	end

	// front: decode the request
	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	bet_front u_front (
		.req_type         (s_axis_tuser),
		.event_mask       (s_axis_tdata[15:0]),
		.axis_z           (s_axis_tdata[31:16]),
		.axis_pitch       (s_axis_tdata[47:32]),
		.axis_bank        (s_axis_tdata[63:48]),
		.axis_heading     (s_axis_tdata[79:64]),
		.timestamp        (s_axis_tdata[111:80]),
		.button_index     (s_axis_tdata[115:112]),
		.axis_mode_enable (axis_mode_q),
		.block_enable     (enable_q),
		.cmd              (front_cmd)
	);

	bet_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_cmd)
	);

	// back: apply to the button store and hold the reply
	bet_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_not_empty),
		.cmd          (head_cmd),
		.cmd_pop      (q_pop),
		.res_valid    (m_axis_tvalid),
		.res_ready    (m_axis_tready),
		.reply_value  (reply_value),
		.pressed_mask (pressed_mask)
	);

	assign m_axis_tdata = {5'b0, pressed_mask, reply_value};

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// Button event tracker bench: directed cases, a back-pressure case, then random
// request traffic over several register settings. Every accepted request runs through
// an in-bench tracker model; each reply is checked against the oldest prediction.
module testbench;
	import bet_pkg::*;

	// one request as the bench sees it; axis[0..3] = z, pitch, bank, heading
	typedef struct {
		logic [2:0]         kind;
		logic [15:0]        ev;
		logic signed [15:0] axis [NUM_AXES];
		logic [31:0]        now;
		logic [3:0]         idx;
	} req_t;

	typedef struct {
		logic [31:0]       value;
		logic [MASK_W-1:0] pressed;
	} reply_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// [15:0] event_mask, [31:16] axis_z, [47:32] axis_pitch, [63:48] axis_bank,
	// [79:64] axis_heading, [111:80] timestamp, [115:112] button_index, [119:116] zero
	logic [119:0] s_axis_tdata;
	// [2:0] req_type
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// [31:0] reply_value, [42:32] pressed_mask, [47:43] zero
	logic [47:0]  m_axis_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// tracker model state
	logic        held_now    [BTN_COUNT];
	logic [31:0] press_stamp [BTN_COUNT];
	logic [31:0] hold_sum    [BTN_COUNT];
	logic [31:0] down_count  [BTN_COUNT];
	logic        axis_on;
	logic        tracker_on;

	reply_t pending_replies [$];
	reply_t head_reply;
	int     mismatch_count;
	bit     no_idle;   // both sides run without gaps while set
	int     rx_hold;   // one-shot long stall for the reply side, in cycles

	button_event_tracker uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- helpers

	function automatic logic [15:0] ev_bit(input int n);
		return 16'(1) << n;
	endfunction

	function automatic req_t mk(input logic [2:0] kind, input logic [15:0] ev = '0,
			input logic [31:0] now = '0, input logic [3:0] idx = '0,
			input logic [15:0] z = '0, input logic [15:0] pitch = '0,
			input logic [15:0] bank = '0, input logic [15:0] heading = '0);
		req_t r;
		r.kind = kind;
		r.ev = ev;
		r.now = now;
		r.idx = idx;
		r.axis[0] = z;
		r.axis[1] = pitch;
		r.axis[2] = bank;
		r.axis[3] = heading;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Apply one request to the model and return the reply it should produce.
	task automatic track_request(input req_t r, output reply_t out);
		int  b;
		int  a;
		int  d;
		logic want_dir;
		out = '{value: '0, pressed: '0};
		// disabled block: zero reply, state frozen
		if (!tracker_on)
			return;
		case (r.kind)
			REQ_EVENT: begin
				// press wins over release on the same request
				for (b = 0; b < NUM_REAL; b++) begin
					if (r.ev[EV_LEFT_PRESS + 2 * b]) begin
						if (!held_now[b]) begin
							held_now[b] = 1'b1;
							press_stamp[b] = r.now;
						end
						down_count[b]++;
					end else if (r.ev[EV_LEFT_RELEASE + 2 * b] && held_now[b]) begin
						held_now[b] = 1'b0;
						hold_sum[b] += r.now - press_stamp[b];
					end
				end
				// a changed axis releases a held direction, else presses by sign
				if (axis_on) begin
					for (a = 0; a < NUM_AXES; a++) begin
						if (r.ev[EV_AXIS_Z + a]) begin
							for (d = 0; d < 2; d++) begin
								b = AXIS_BASE + 2 * a + d;
								want_dir = d ? (r.axis[a] < 0) : (r.axis[a] > 0);
								if (held_now[b]) begin
									held_now[b] = 1'b0;
									hold_sum[b] += r.now - press_stamp[b];
								end else if (want_dir) begin
									held_now[b] = 1'b1;
									press_stamp[b] = r.now;
									down_count[b]++;
								end
							end
						end
					end
				end
			end
			REQ_FLUSH: begin
				for (b = 0; b < BTN_COUNT; b++) begin
					held_now[b] = 1'b0;
					press_stamp[b] = r.now;
					hold_sum[b] = '0;
					down_count[b] = '0;
				end
			end
			REQ_RD_CNT: begin
				if (r.idx < BTN_COUNT) begin
					out.value = down_count[r.idx];
					down_count[r.idx] = '0;
				end
			end
			REQ_RD_STATE: begin
				if (r.idx < BTN_COUNT)
					out.value = {31'b0, held_now[r.idx]};
			end
			REQ_RD_HOLD: begin
				// held button: live time, timestamp restarts, total kept
				if (r.idx < BTN_COUNT) begin
					if (!held_now[r.idx]) begin
						out.value = hold_sum[r.idx];
						hold_sum[r.idx] = '0;
					end else begin
						out.value = r.now - press_stamp[r.idx];
						press_stamp[r.idx] = r.now;
					end
				end
			end
			default: begin
			end
		endcase
		for (b = 0; b < BTN_COUNT; b++)
			out.pressed[b] = held_now[b];
	endtask

	// Offer one request, wait for the handshake, predict, then maybe idle.
	task automatic send_request(input req_t r);
		reply_t want;
		int     gap;
		@(negedge clk);
		s_axis_tuser = r.kind;
		s_axis_tdata = {4'b0, r.idx, r.now, r.axis[3], r.axis[2], r.axis[1], r.axis[0],
			r.ev};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		track_request(r, want);
		pending_replies.push_back(want);
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stop offering, wait out all replies (bounded), then a few spare cycles.
	task automatic drain();
		int waited;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		waited = 0;
		while (pending_replies.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_replies.size() != 0) begin
			report_mismatch("replies missing", pending_replies.size(), 0);
			pending_replies.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// APB write; only ever done with the block idle.
	task automatic set_register(input logic sel, input logic [31:0] value);
		drain();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {sel, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == REG_AXIS_MODE)
			axis_on = value[0];
		else
			tracker_on = value[0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// ---------------------------------------------------------------- tests

	// block off after reset: zero replies, events dropped
	task automatic test_disabled();
		send_request(mk(REQ_EVENT, ev_bit(EV_LEFT_PRESS), 32'h40));
		send_request(mk(REQ_RD_CNT, '0, 32'h50, 4'd0));
		send_request(mk(REQ_RD_STATE, '0, 32'h60, 4'd0));
	endtask

	task automatic test_real_buttons();
		send_request(mk(REQ_EVENT, ev_bit(EV_LEFT_PRESS), 32'h100));
		// press again while held: count up, stamp kept; release ignored
		send_request(mk(REQ_EVENT, ev_bit(EV_LEFT_PRESS) | ev_bit(EV_LEFT_RELEASE),
			32'h200));
		// release of a button not held
		send_request(mk(REQ_EVENT, ev_bit(EV_RIGHT_RELEASE), 32'h250));
		send_request(mk(REQ_EVENT, ev_bit(EV_MID_PRESS) | ev_bit(EV_LEFT_RELEASE),
			32'h300));
		send_request(mk(REQ_RD_CNT, '0, 32'h400, 4'd0));
		send_request(mk(REQ_RD_HOLD, '0, 32'h480, 4'd0));
		// held button: live time, stamp restarts
		send_request(mk(REQ_RD_HOLD, '0, 32'h500, 4'd2));
	endtask

	task automatic test_axes();
		// axis mode off: axis changes ignored
		send_request(mk(REQ_EVENT, ev_bit(EV_AXIS_Z), 32'h1000, '0, 16'sd5));
		set_register(REG_AXIS_MODE, 32'd1);
		// every mask bit, axis extremes
		send_request(mk(REQ_EVENT, 16'hFFFF, 32'h2000, '0, 16'sd1, -16'sd1, 16'h7FFF,
			16'h8000));
		// change on a held direction releases even with the same sign
		send_request(mk(REQ_EVENT, ev_bit(EV_AXIS_Z), 32'h2400, '0, 16'sd3));
		// zero axis: release held, other side stays up
		send_request(mk(REQ_EVENT, ev_bit(EV_AXIS_PITCH), 32'h2800));
		send_request(mk(REQ_RD_STATE, '0, 32'h2900, 4'd7));
		send_request(mk(REQ_RD_CNT, '0, 32'h2A00, 4'(BTN_COUNT - 1)));
		send_request(mk(REQ_RD_HOLD, '0, 32'h2B00, 4'(AXIS_BASE)));
	endtask

	task automatic test_edges();
		int c;
		// index past the last button
		send_request(mk(REQ_RD_CNT, '0, 32'h3000, 4'(BTN_COUNT)));
		send_request(mk(REQ_RD_HOLD, '0, 32'h3100, 4'hF));
		// spare request codes
		for (c = REQ_RD_HOLD + 1; c < 8; c++)
			send_request(mk(3'(c), 16'hFFFF, 32'h3200, 4'd2));
		// timestamp behind the press stamp: hold time wraps
		send_request(mk(REQ_RD_HOLD, '0, 32'h10, 4'd2));
		send_request(mk(REQ_FLUSH, '0, 32'hFFFF_FFFF));
		send_request(mk(REQ_RD_HOLD, '0, 32'h5, 4'd0));
	endtask

	// reply side stalls for a long stretch while requests keep coming
	task automatic test_pressure();
		int k;
		rx_hold = 48;
		no_idle = 1'b1;
		for (k = 0; k < 10; k++)
			send_request(mk(REQ_RD_STATE, '0, 32'h100 * k, 4'(k % BTN_COUNT)));
		no_idle = 1'b0;
		drain();
	endtask

	// Mostly well-formed events and reads on a running clock, plus raw noise.
	task automatic test_random(input int count, input int calm_at, input int calm_len);
		req_t              r;
		logic [31:0]       stamp;
		logic signed [15:0] ax;
		int                pick;
		int                sel_kind;
		int                k;
		int                b;
		int                a;
		stamp = $urandom;
		for (k = 0; k < count; k++) begin
			no_idle = (k >= calm_at && k < calm_at + calm_len);
			stamp = ($urandom_range(0, 15) == 0) ? $urandom
				: stamp + $urandom_range(0, 'h40000);
			r = mk(REQ_EVENT, '0, stamp);
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				for (b = 0; b < NUM_REAL; b++) begin
					sel_kind = $urandom_range(0, 5);
					if (sel_kind < 2 || sel_kind == 4)
						r.ev[EV_LEFT_PRESS + 2 * b] = 1'b1;
					if (sel_kind >= 2 && sel_kind <= 4)
						r.ev[EV_LEFT_RELEASE + 2 * b] = 1'b1;
				end
				for (a = 0; a < NUM_AXES; a++) begin
					r.ev[EV_AXIS_Z + a] = ($urandom_range(0, 2) == 0);
					case ($urandom_range(0, 3))
						0: ax = '0;
						1: ax = 16'($urandom_range(1, 100));
						2: ax = -16'($urandom_range(1, 100));
						default: ax = 16'($urandom);
					endcase
					r.axis[a] = ax;
				end
			end else if (pick < 85) begin
				r.kind = 3'(REQ_RD_CNT + $urandom_range(0, 2));
				r.idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(BTN_COUNT, 15))
					: 4'($urandom_range(0, BTN_COUNT - 1));
			end else if (pick < 87) begin
				r.kind = REQ_FLUSH;
			end else begin
				r.kind = 3'($urandom_range(0, 7));
				r.ev = 16'($urandom);
				for (a = 0; a < NUM_AXES; a++)
					r.axis[a] = 16'($urandom);
				r.now = $urandom;
				r.idx = 4'($urandom);
			end
			send_request(r);
		end
		no_idle = 1'b0;
	endtask

	// ---------------------------------------------------------------- processes

	// reply sink: random stall before each reply, or the one-shot long hold
	initial begin : reply_sink
		int stall;
		m_axis_tready = 1'b0;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end
			if (stall > 0) begin
				@(negedge clk);
				m_axis_tready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// reply checker: oldest prediction first
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected reply", m_axis_tdata[31:0], 0);
			end else begin
				head_reply = pending_replies.pop_front();
				if (m_axis_tdata[31:0] !== head_reply.value)
					report_mismatch("reply_value", m_axis_tdata[31:0], head_reply.value);
				if (m_axis_tdata[42:32] !== head_reply.pressed)
					report_mismatch("pressed_mask", 32'(m_axis_tdata[42:32]),
						32'(head_reply.pressed));
			end
		end
	end

	// run limit, far above the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin : main_seq
		int b;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatch_count = 0;
		no_idle = 1'b0;
		rx_hold = 0;
		axis_on = 1'b0;
		tracker_on = 1'b0;
		for (b = 0; b < BTN_COUNT; b++) begin
			held_now[b] = 1'b0;
			press_stamp[b] = '0;
			hold_sum[b] = '0;
			down_count[b] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_disabled();
		set_register(REG_ENABLE, 32'd1);
		test_real_buttons();
		test_axes();
		test_edges();
		test_pressure();

		// random traffic over several settings
		test_random(350, 100, 60);
		set_register(REG_AXIS_MODE, 32'd0);
		test_random(250, 120, 80);
		set_register(REG_ENABLE, 32'd0);
		set_register(REG_AXIS_MODE, 32'd1);
		test_random(60, 0, 0);
		set_register(REG_ENABLE, 32'd1);
		test_random(650, 300, 50);
		drain();

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
sv/bet_pkg.sv
sv/bet_front.sv
sv/bet_queue.sv
sv/bet_back.sv
sv/button_event_tracker.sv
tb/sv/testbench.sv
